// File: rtl/dipdc_pkg.sv
package dipdc_pkg;

  localparam int ErrW    = 16;
  localparam int DiffW   = 17;
  localparam int SpdW    = 24;
  localparam int GainW   = 24;
  localparam int DmaxW   = 23;
  localparam int FracW   = 16;
  localparam int AccW    = 44;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 24;

  typedef logic signed [ErrW-1:0]  err_t;
  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [SpdW-1:0]  speed_t;
  typedef logic signed [GainW-1:0] gain_t;
  typedef logic        [DmaxW-1:0] dmax_t;
  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic [CfgIdxW-1:0]      cfg_idx_t;
  typedef logic [CfgW-1:0]         cfg_data_t;

  localparam cfg_idx_t RegGainP    = 3'd0;
  localparam cfg_idx_t RegGainI    = 3'd1;
  localparam cfg_idx_t RegGainD    = 3'd2;
  localparam cfg_idx_t RegFloor    = 3'd3;
  localparam cfg_idx_t RegCeiling  = 3'd4;
  localparam cfg_idx_t RegDiffMax  = 3'd5;

  localparam gain_t  GainPRst   = 24'sd512000;
  localparam gain_t  GainIRst   = 24'sd51200;
  localparam gain_t  GainDRst   = 24'sd0;
  localparam speed_t FloorRst   = 24'sd0;
  localparam speed_t CeilRst    = 24'sd10000;
  localparam dmax_t  DiffMaxRst = 23'd3000;

endpackage

// File: rtl/dipdc_in_if.sv
interface dipdc_in_if;
  logic                valid;
  logic                ready;
  dipdc_pkg::err_t     error_left;
  dipdc_pkg::err_t     error_right;

  modport source (output valid, output error_left, output error_right, input ready);
  modport sink   (input valid, input error_left, input error_right, output ready);
endinterface

// File: rtl/dipdc_out_if.sv
interface dipdc_out_if;
  logic                valid;
  logic                ready;
  dipdc_pkg::speed_t   left_speed;
  dipdc_pkg::speed_t   right_speed;

  modport source (output valid, output left_speed, output right_speed, input ready);
  modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

// File: rtl/dipdc_cfg_if.sv
interface dipdc_cfg_if;
  logic                 valid;
  logic                 ready;
  dipdc_pkg::cfg_idx_t  index;
  dipdc_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/dual_incremental_pid_diff_clamp_top.sv
// Path: an accepted input beat is held in the input register, then its result
// is written to the result register, when the result side is not stalled.
// Throughput: one beat per cycle unless the result side stalls; wheel history
// feeds back combinationally via multipliers, sum, clamp and difference limit.
// Reset (rst_n low, synchronous): gains and limits return to their defaults,
// speed and error history clear, both channels drain empty.
module dual_incremental_pid_diff_clamp_top (
  input  logic         clk,
  input  logic         rst_n,
  dipdc_in_if.sink     in_if,
  dipdc_out_if.source  out_if,
  dipdc_cfg_if.sink    cfg_if
);
  import dipdc_pkg::*;

  // configuration
  gain_t  gain_p_r, gain_i_r, gain_d_r;
  speed_t floor_r, ceil_r;
  dmax_t  diff_max_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r   <= GainPRst;
      gain_i_r   <= GainIRst;
      gain_d_r   <= GainDRst;
      floor_r    <= FloorRst;
      ceil_r     <= CeilRst;
      diff_max_r <= DiffMaxRst;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        RegGainP:   gain_p_r   <= $signed(cfg_if.data);
        RegGainI:   gain_i_r   <= $signed(cfg_if.data);
        RegGainD:   gain_d_r   <= $signed(cfg_if.data);
        RegFloor:   floor_r    <= $signed(cfg_if.data);
        RegCeiling: ceil_r     <= $signed(cfg_if.data);
        RegDiffMax: diff_max_r <= cfg_if.data[DmaxW-1:0];
        default: ;
      endcase
    end
  end

  // input stage and output register handshake
  logic   s1_valid_r;
  err_t   s1_err_r [2];
  logic   out_valid_r;
  speed_t out_left_r, out_right_r;
  logic   in_fire, adv;

  assign adv          = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || adv;
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_if.valid       = out_valid_r;
  assign out_if.left_speed  = out_left_r;
  assign out_if.right_speed = out_right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire)  s1_valid_r <= 1'b1;
      else if (adv) s1_valid_r <= 1'b0;
      if (adv)                out_valid_r <= 1'b1;
      else if (out_if.ready)  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_err_r[0] <= in_if.error_left;
      s1_err_r[1] <= in_if.error_right;
    end
  end

  // per-wheel history and increment
  speed_t prev_spd_r  [2];
  err_t   last_err_r  [2];
  diff_t  last_diff_r [2];
  diff_t  d_w         [2];
  speed_t spd_w       [2];

  acc_t lo, hi;
  assign lo = acc_t'(floor_r) <<< FracW;
  assign hi = acc_t'(ceil_r) <<< FracW;

  for (genvar w = 0; w < 2; w++) begin : g_wheel
    logic signed [DiffW:0]             dd;
    logic signed [GainW+DiffW-1:0]     prod_p;
    logic signed [GainW+ErrW-1:0]      prod_i;
    logic signed [GainW+DiffW:0]       prod_d;
    acc_t                              base, sum, sat, shifted;
    logic                              rnd;

    assign d_w[w]  = DiffW'(s1_err_r[w]) - DiffW'(last_err_r[w]);
    assign dd      = (DiffW+1)'(d_w[w]) - (DiffW+1)'(last_diff_r[w]);
    assign prod_p  = gain_p_r * d_w[w];
    assign prod_i  = gain_i_r * s1_err_r[w];
    assign prod_d  = gain_d_r * dd;
    assign base    = acc_t'(prev_spd_r[w]) <<< FracW;
    assign sum     = base + acc_t'(prod_p) + acc_t'(prod_i) + acc_t'(prod_d);
    assign sat     = (sum < lo) ? lo : ((sum > hi) ? hi : sum);
    assign shifted = sat >>> FracW;
    // truncate toward zero: bump negative values that lost fraction bits
    assign rnd     = sat[AccW-1] && (sat[FracW-1:0] != '0);
    assign spd_w[w] = $signed(shifted[SpdW-1:0] + {{(SpdW-1){1'b0}}, rnd});
  end

  // difference limit: lower only the faster wheel
  logic signed [SpdW:0] lim, l_ext, r_ext, l_hi, r_hi;
  speed_t               l_fin, r_fin;

  assign lim   = $signed({2'b00, diff_max_r});
  assign l_ext = (SpdW+1)'(spd_w[0]);
  assign r_ext = (SpdW+1)'(spd_w[1]);
  assign l_hi  = l_ext + lim;
  assign r_hi  = r_ext + lim;

  always_comb begin
    l_fin = spd_w[0];
    r_fin = spd_w[1];
    if (l_ext > r_ext) begin
      if (l_ext > r_hi) l_fin = r_hi[SpdW-1:0];
    end else begin
      if (r_ext > l_hi) r_fin = l_hi[SpdW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        prev_spd_r[i]  <= '0;
        last_err_r[i]  <= '0;
        last_diff_r[i] <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i < 2; i++) begin
        last_err_r[i]  <= s1_err_r[i];
        last_diff_r[i] <= d_w[i];
      end
      prev_spd_r[0] <= l_fin;
      prev_spd_r[1] <= r_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_left_r  <= l_fin;
      out_right_r <= r_fin;
    end
  end

`ifndef SYNTHESIS
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_if.valid)
    else $error("result beat lost after advance");

  a_state_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (prev_spd_r[0] == out_if.left_speed &&
                      prev_spd_r[1] == out_if.right_speed))
    else $error("kept speeds differ from pending result");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_if.ready)
    else $error("input stalled with empty stage");
`endif

endmodule
